// File: src/glyph_font_buffer_validator_core_assert.svh
// Assertion macros shared by the font buffer validator RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef GLYPH_FONT_BUFFER_VALIDATOR_CORE_ASSERT_SVH
`define GLYPH_FONT_BUFFER_VALIDATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define GFBV_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GFBV_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/gfbv_pkg.sv
// Types and constants for the font buffer validator.
// No dependencies; used by gfbv_parse and the top level.
package gfbv_pkg;

  localparam int OFFS_W  = 20;
  localparam int COUNT_W = 18;

  localparam logic [OFFS_W-1:0]  OFFSET_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

  localparam logic [7:0] MAX_WIDTH    = 8'd128;
  localparam logic [7:0] MAX_HEIGHT   = 8'd64;
  localparam logic [7:0] ASCII_LOW    = 8'd32;
  localparam logic [7:0] ASCII_HIGH   = 8'd127;
  localparam int         MIN_BUF_BYTES = 5;

  typedef enum logic [2:0] {
    PH_LEAD = 3'd0,
    PH_CONT = 3'd1,
    PH_OFFS = 3'd2,
    PH_WID  = 3'd3,
    PH_HEI  = 3'd4,
    PH_STR  = 3'd5,
    PH_DATA = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TOO_SMALL  = 3'd1,
    ST_BAD_UTF8   = 3'd2,
    ST_HDR_TRUNC  = 3'd3,
    ST_BAD_HDR    = 3'd4,
    ST_DATA_TRUNC = 3'd5
  } status_t;

  // Packed so that status lands in the lowest bits.
  typedef struct packed {
    logic [OFFS_W-1:0]  error_offset;
    logic [COUNT_W-1:0] non_ascii_count;
    logic [COUNT_W-1:0] glyph_count;
    status_t            status;
  } result_t;

  localparam int RES_W  = $bits(result_t);
  localparam int OUT_DW = ((RES_W + 7) / 8) * 8;

endpackage

// File: src/gfbv_parse.sv
// Record parser of the font buffer validator: parse state and verdict logic.
// Depends on gfbv_pkg.
module gfbv_parse
  import gfbv_pkg::*;
#(
  parameter int MAX_BUFFER_BYTES = 1048576
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_valid,
  input  logic [7:0] byte_data,
  input  logic       byte_last,
  output logic       res_valid,
  output result_t    res
);

  localparam int POS_W = $clog2(MAX_BUFFER_BYTES + 1);
  localparam int CMP_W = (POS_W > OFFS_W) ? POS_W : OFFS_W;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_BUFFER_BYTES);
  localparam logic [POS_W-1:0] POS_SMALL = POS_W'(MIN_BUF_BYTES - 1);

  phase_t             phase_r, phase_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [OFFS_W-1:0]  rec_start_r, rec_start_nxt;
  logic [1:0]         cont_left_r, cont_left_nxt;
  logic [7:0]         width_r, width_nxt;
  logic [7:0]         height_r, height_nxt;
  logic [14:0]        data_left_r, data_left_nxt;
  logic [COUNT_W-1:0] rec_cnt_r, rec_cnt_nxt;
  logic [COUNT_W-1:0] wide_cnt_r, wide_cnt_nxt;
  status_t            err_r, err_nxt;

  logic [CMP_W-1:0]   pos_wide;
  logic [OFFS_W-1:0]  pos_sat;
  logic               lead_ok;
  logic [1:0]         lead_extra;
  logic [15:0]        data_prod;
  logic [8:0]         min_stride;
  logic               hdr_bad;

  always_comb begin
    pos_wide = CMP_W'(pos_r);
    pos_sat  = (pos_wide > CMP_W'(OFFSET_MAX)) ? OFFSET_MAX : pos_wide[OFFS_W-1:0];

    lead_ok    = 1'b1;
    lead_extra = 2'd0;
    if (byte_data[7] == 1'b0) begin
      lead_extra = 2'd0;
    end else if (byte_data[7:5] == 3'b110) begin
      lead_extra = 2'd1;
    end else if (byte_data[7:4] == 4'b1110) begin
      lead_extra = 2'd2;
    end else if (byte_data[7:3] == 5'b11110) begin
      lead_extra = 2'd3;
    end else begin
      lead_ok = 1'b0;
    end

    data_prod  = 16'(byte_data) * 16'(width_r);
    min_stride = (9'(height_r) + 9'd7) >> 3;
    hdr_bad    = (width_r == 8'd0) || (height_r == 8'd0) || (width_r > MAX_WIDTH) ||
                 (height_r > MAX_HEIGHT) || (9'(byte_data) < min_stride);
  end

  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    rec_start_nxt = rec_start_r;
    cont_left_nxt = cont_left_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    data_left_nxt = data_left_r;
    rec_cnt_nxt   = rec_cnt_r;
    wide_cnt_nxt  = wide_cnt_r;
    err_nxt       = err_r;
    res_valid     = 1'b0;
    res           = '0;

    if (byte_valid) begin
      if (err_r == ST_OK) begin
        unique case (phase_r)
          PH_LEAD: begin
            rec_start_nxt = pos_sat;
            if (!lead_ok) begin
              err_nxt = ST_BAD_UTF8;
            end else begin
              // Counting at the lead byte is safe: an unfinished record ends in an error.
              if (rec_cnt_r < COUNT_MAX) rec_cnt_nxt = rec_cnt_r + COUNT_W'(1);
              if (((byte_data < ASCII_LOW) || (byte_data > ASCII_HIGH)) &&
                  (wide_cnt_r < COUNT_MAX)) begin
                wide_cnt_nxt = wide_cnt_r + COUNT_W'(1);
              end
              cont_left_nxt = lead_extra;
              phase_nxt     = (lead_extra != 2'd0) ? PH_CONT : PH_OFFS;
            end
          end
          PH_CONT: begin
            if (cont_left_r <= 2'd1) begin
              cont_left_nxt = 2'd0;
              phase_nxt     = PH_OFFS;
            end else begin
              cont_left_nxt = cont_left_r - 2'd1;
            end
          end
          PH_OFFS: phase_nxt = PH_WID;
          PH_WID: begin
            width_nxt = byte_data;
            phase_nxt = PH_HEI;
          end
          PH_HEI: begin
            height_nxt = byte_data;
            phase_nxt  = PH_STR;
          end
          PH_STR: begin
            if (hdr_bad) begin
              err_nxt = ST_BAD_HDR;
            end else begin
              data_left_nxt = data_prod[14:0];
              phase_nxt     = (data_prod[14:0] == 15'd0) ? PH_LEAD : PH_DATA;
            end
          end
          default: begin
            if (data_left_r <= 15'd1) begin
              data_left_nxt = 15'd0;
              phase_nxt     = PH_LEAD;
            end else begin
              data_left_nxt = data_left_r - 15'd1;
            end
          end
        endcase
      end

      pos_nxt = (pos_r < POS_MAX) ? pos_r + POS_W'(1) : POS_MAX;

      if (byte_last) begin
        res_valid = 1'b1;
        if (pos_r < POS_SMALL) begin
          res.status = ST_TOO_SMALL;
        end else if (err_nxt != ST_OK) begin
          res.status       = err_nxt;
          res.error_offset = rec_start_nxt;
        end else if (phase_nxt == PH_DATA) begin
          res.status       = ST_DATA_TRUNC;
          res.error_offset = rec_start_nxt;
        end else if (phase_nxt != PH_LEAD) begin
          res.status       = ST_HDR_TRUNC;
          res.error_offset = rec_start_nxt;
        end else begin
          res.status          = ST_OK;
          res.glyph_count     = rec_cnt_nxt;
          res.non_ascii_count = wide_cnt_nxt;
        end

        // The buffer is done; start the next one from scratch.
        phase_nxt     = PH_LEAD;
        pos_nxt       = '0;
        rec_start_nxt = '0;
        cont_left_nxt = '0;
        width_nxt     = '0;
        height_nxt    = '0;
        data_left_nxt = '0;
        rec_cnt_nxt   = '0;
        wide_cnt_nxt  = '0;
        err_nxt       = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEAD;
      pos_r       <= '0;
      rec_start_r <= '0;
      cont_left_r <= '0;
      width_r     <= '0;
      height_r    <= '0;
      data_left_r <= '0;
      rec_cnt_r   <= '0;
      wide_cnt_r  <= '0;
      err_r       <= ST_OK;
    end else begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      rec_start_r <= rec_start_nxt;
      cont_left_r <= cont_left_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      data_left_r <= data_left_nxt;
      rec_cnt_r   <= rec_cnt_nxt;
      wide_cnt_r  <= wide_cnt_nxt;
      err_r       <= err_nxt;
    end
  end

endmodule

// File: src/glyph_font_buffer_validator_core.sv
// Channel  | Dir | Handshake             | Payload
// in       | in  | in_tvalid/in_tready   | in_tdata[7:0] data_byte, in_tlast last_byte
// out      | out | out_tvalid/out_tready | out_tdata: status, glyph_count,
//          |     |                       |   non_ascii_count, error_offset
//
// One byte per cycle can be taken while in_tready is high; each byte is held in the input register and
// is checked by gfbv_parse at the next edge, where a last byte's verdict enters the queue.
// out_tvalid is high whenever the queue holds a verdict.
// The result queue holds three verdicts. in_tready drops only while the queue is full, or
// holds two verdicts with a last byte staged; a receiver that never stalls never stalls us.
// Reset is synchronous and active low.
// Top level of the font buffer validator; depends on gfbv_pkg, gfbv_parse and the
// assertion macro header.
`include "glyph_font_buffer_validator_core_assert.svh"

module glyph_font_buffer_validator_core
  import gfbv_pkg::*;
#(
  parameter int MAX_BUFFER_BYTES = 1048576
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] data_byte
  input  logic              in_tlast,   // last_byte
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata   // status, glyph_count, non_ascii_count,
                                        // error_offset, then zero fill
);

  logic       stage_valid_r, stage_valid_nxt;
  logic [7:0] stage_data_r, stage_data_nxt;
  logic       stage_last_r, stage_last_nxt;

  logic [1:0] q_cnt_r, q_cnt_nxt;
  result_t    q0_r, q0_nxt;
  result_t    q1_r, q1_nxt;
  result_t    q2_r, q2_nxt;
  logic [1:0] fill;

  logic       in_fire;
  logic       pop;
  logic       res_valid;
  result_t    res;

  // Accept only when a verdict from both the staged byte and the new one has room.
  assign in_tready = (q_cnt_r != 2'd3) &&
                     !((q_cnt_r == 2'd2) && stage_valid_r && stage_last_r);
  assign in_fire   = in_tvalid && in_tready;
  assign pop       = (q_cnt_r != 2'd0) && out_tready;

  gfbv_parse #(
    .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_valid(stage_valid_r),
    .byte_data (stage_data_r),
    .byte_last (stage_last_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    stage_valid_nxt = in_fire;
    stage_data_nxt  = in_fire ? in_tdata : stage_data_r;
    stage_last_nxt  = in_fire ? in_tlast : stage_last_r;

    // The queue shifts toward q0 on a pop; a new verdict lands behind the survivors.
    fill      = pop ? q_cnt_r - 2'd1 : q_cnt_r;
    q0_nxt    = pop ? q1_r : q0_r;
    q1_nxt    = pop ? q2_r : q1_r;
    q2_nxt    = q2_r;
    q_cnt_nxt = fill;

    if (res_valid) begin
      q_cnt_nxt = fill + 2'd1;
      unique case (fill)
        2'd0:    q0_nxt = res;
        2'd1:    q1_nxt = res;
        default: q2_nxt = res;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      q_cnt_r       <= 2'd0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      q_cnt_r       <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stage_data_r <= stage_data_nxt;
    stage_last_r <= stage_last_nxt;
    q0_r         <= q0_nxt;
    q1_r         <= q1_nxt;
    q2_r         <= q2_nxt;
  end

  assign out_tvalid = (q_cnt_r != 2'd0);
  assign out_tdata  = OUT_DW'(q0_r);

  `GFBV_ASSERT_IMP(a_full_blocks_input, q_cnt_r == 2'd3, !in_tready,
                   "byte taken while the result queue is full")
  `GFBV_ASSERT_IMP(a_verdict_has_room, stage_valid_r && stage_last_r, q_cnt_r != 2'd3,
                   "verdict would overflow the result queue")
  `GFBV_ASSERT_IMP(a_counts_only_ok, (q_cnt_r != 2'd0) && (q0_r.status != ST_OK),
                   (q0_r.glyph_count == '0) && (q0_r.non_ascii_count == '0),
                   "counts nonzero on error verdict")
  `GFBV_ASSERT_NXT(a_held_verdict_stays, (q_cnt_r != 2'd0) && !out_tready,
                   (q_cnt_r != 2'd0) && $stable(q0_r), "verdict changed while stalled")

endmodule

// File: tb/sv/glyph_font_buffer_validator_core_tb.sv
// Self-checking testbench for the font buffer validator: streams directed and random
// font buffers byte by byte; verdicts are checked against typed rows (directed) or its own parser model.
// Depends on gfbv_pkg and glyph_font_buffer_validator_core.
`timescale 1ns / 100ps

module glyph_font_buffer_validator_core_tb
  import gfbv_pkg::*;
;

  localparam int BUF_LIMIT      = 1048576;
  localparam int RANDOM_BYTES   = 1650;
  localparam int MIN_VERDICTS   = 60;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SHOWN_ERRORS   = 10;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata   = 8'h00;
  logic              in_tlast   = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;

  always #5 clk = ~clk;

  glyph_font_buffer_validator_core #(
    .MAX_BUFFER_BYTES(BUF_LIMIT)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Parser state kept alongside the block.
  phase_t      ps_phase;
  logic [20:0] ps_pos;
  logic [19:0] ps_rec_start;
  logic [1:0]  ps_cont_left;
  logic [7:0]  ps_width;
  logic [7:0]  ps_height;
  logic [14:0] ps_data_left;
  logic [17:0] ps_glyphs;
  logic [17:0] ps_wide;
  status_t     ps_err;

  result_t    verdict_q[$];
  logic [7:0] buf_q[$];

  int  mismatches     = 0;
  int  tx_burst_left  = 0;
  int  buffers_sent   = 0;
  int  bytes_sent     = 0;
  int  verdicts_due   = 0;
  int  verdicts_seen  = 0;
  int  status_seen[6] = '{default: 0};
  int  idle_cycles    = 0;
  logic [9:0] rx_cyc  = '0;
  int  rx_hold        = 0;
  logic hold_req      = 1'b0;
  logic hold_done     = 1'b0;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         typed;
    status_t    st;
    int         glyphs;
    int         wide;
    int         offs;
  } dir_row_t;

  dir_row_t dir_rows[28];

  function automatic void clear_parser();
    ps_phase     = PH_LEAD;
    ps_pos       = '0;
    ps_rec_start = '0;
    ps_cont_left = '0;
    ps_width     = '0;
    ps_height    = '0;
    ps_data_left = '0;
    ps_glyphs    = '0;
    ps_wide      = '0;
    ps_err       = ST_OK;
  endfunction

  // Advances the parser by one byte; returns 1 with the verdict on the last byte.
  function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                    output result_t v);
    int          extra;
    int          stride_min;
    int          prod;
    logic [20:0] pos;
    pos = ps_pos;
    v   = '0;
    if (ps_err == ST_OK) begin
      case (ps_phase)
        PH_LEAD: begin
          casez (b)
            8'b0???????: extra = 0;
            8'b110?????: extra = 1;
            8'b1110????: extra = 2;
            8'b11110???: extra = 3;
            default:     extra = -1;
          endcase
          ps_rec_start = (pos > OFFSET_MAX) ? OFFSET_MAX : pos[19:0];
          if (extra < 0) begin
            ps_err = ST_BAD_UTF8;
          end else begin
            if (ps_glyphs != COUNT_MAX) ps_glyphs++;
            if ((b < ASCII_LOW || b > ASCII_HIGH) && ps_wide != COUNT_MAX) ps_wide++;
            ps_cont_left = extra[1:0];
            ps_phase     = (extra > 0) ? PH_CONT : PH_OFFS;
          end
        end
        PH_CONT: begin
          if (ps_cont_left <= 2'd1) begin
            ps_cont_left = '0;
            ps_phase     = PH_OFFS;
          end else begin
            ps_cont_left--;
          end
        end
        PH_OFFS: ps_phase = PH_WID;
        PH_WID: begin
          ps_width = b;
          ps_phase = PH_HEI;
        end
        PH_HEI: begin
          ps_height = b;
          ps_phase  = PH_STR;
        end
        PH_STR: begin
          stride_min = (int'(ps_height) + 7) / 8;
          if (ps_width == 0 || ps_height == 0 || ps_width > MAX_WIDTH ||
              ps_height > MAX_HEIGHT || int'(b) < stride_min) begin
            ps_err = ST_BAD_HDR;
          end else begin
            prod         = int'(b) * int'(ps_width);
            ps_data_left = prod[14:0];
            ps_phase     = (ps_data_left == 0) ? PH_LEAD : PH_DATA;
          end
        end
        default: begin
          if (ps_data_left <= 15'd1) begin
            ps_data_left = '0;
            ps_phase     = PH_LEAD;
          end else begin
            ps_data_left--;
          end
        end
      endcase
    end
    ps_pos = (pos < BUF_LIMIT) ? pos + 21'd1 : 21'(BUF_LIMIT);
    if (!last) return 1'b0;

    if (pos < MIN_BUF_BYTES - 1) begin
      v.status = ST_TOO_SMALL;
    end else if (ps_err != ST_OK) begin
      v.status       = ps_err;
      v.error_offset = ps_rec_start;
    end else if (ps_phase == PH_DATA) begin
      v.status       = ST_DATA_TRUNC;
      v.error_offset = ps_rec_start;
    end else if (ps_phase != PH_LEAD) begin
      v.status       = ST_HDR_TRUNC;
      v.error_offset = ps_rec_start;
    end else begin
      v.status          = ST_OK;
      v.glyph_count     = ps_glyphs;
      v.non_ascii_count = ps_wide;
    end
    clear_parser();
    return 1'b1;
  endfunction

  // Random buffer: mostly well-formed records, some cut short, corrupted or padded,
  // and some plain noise.
  function automatic void build_buffer();
    int   kind;
    int   n;
    int   g;
    int   sel;
    int   w;
    int   h;
    int   s;
    int   cut;
    bit   stop;
    buf_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      n = $urandom_range(1, 10);
      repeat (n) buf_q.push_back(8'($urandom));
      return;
    end
    n    = $urandom_range(1, 3);
    stop = 1'b0;
    for (g = 0; g < n && !stop; g++) begin
      sel = $urandom_range(0, 4);
      case (sel)
        0:       buf_q.push_back(8'($urandom_range(32, 127)));
        1:       buf_q.push_back(8'($urandom_range(0, 31)));
        2:       buf_q.push_back(8'($urandom_range(8'hC0, 8'hDF)));
        3:       buf_q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
        default: buf_q.push_back(8'($urandom_range(8'hF0, 8'hF7)));
      endcase
      repeat ((sel < 2) ? 0 : sel - 1) buf_q.push_back(8'($urandom));
      buf_q.push_back(8'($urandom));
      kind = $urandom_range(0, 99);
      if (kind < 85) begin
        w = $urandom_range(1, 4);
        h = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(1, 64);
        s = (h + 7) / 8 + $urandom_range(0, 1);
      end else if (kind < 91) begin
        // Wide glyph, kept short so the data part stays small.
        w = ($urandom_range(0, 1) == 0) ? 128 : $urandom_range(5, 128);
        h = $urandom_range(1, 8);
        s = 1;
      end else begin
        w    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 255);
        h    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 255);
        s    = $urandom_range(0, 3);
        stop = 1'b1;
      end
      buf_q.push_back(8'(w));
      buf_q.push_back(8'(h));
      buf_q.push_back(8'(s));
      repeat (stop ? $urandom_range(0, 3) : s * w) buf_q.push_back(8'($urandom));
    end
    kind = $urandom_range(0, 99);
    if (kind >= 60 && kind < 78 && buf_q.size() > 1) begin
      cut = $urandom_range(1, buf_q.size() - 1);
      while (buf_q.size() > cut) void'(buf_q.pop_back());
    end else if (kind >= 78 && kind < 90) begin
      buf_q[$urandom_range(0, buf_q.size() - 1)] = 8'($urandom);
    end else if (kind >= 90) begin
      repeat ($urandom_range(1, 4)) buf_q.push_back(8'($urandom));
    end
  endfunction

  // Offers one byte in bursts with random gaps and records its verdict once taken.
  task automatic send_byte(input logic [7:0] b, input logic last,
                           input bit typed, input result_t typed_res);
    int      gap;
    result_t v;
    if (tx_burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      tx_burst_left = $urandom_range(1, 40);
    end
    tx_burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    if (parse_byte(b, last, v)) begin
      verdict_q.push_back(typed ? typed_res : v);
      verdicts_due++;
    end
  endtask

  task automatic send_buffer();
    int i;
    for (i = 0; i < buf_q.size(); i++) begin
      send_byte(buf_q[i], i == buf_q.size() - 1, 1'b0, '0);
    end
    buffers_sent++;
  endtask

  task automatic drain_verdicts();
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  function automatic void note_mismatch(input string what, input logic [19:0] want,
                                        input logic [19:0] got);
    mismatches++;
    if (mismatches <= SHOWN_ERRORS) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    end
  endfunction

  // Receiver: steps through four stall patterns chosen by rx_cyc[9:8], with one long hold-off.
  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 10'd1;
    if (rx_hold != 0) begin
      out_tready <= 1'b0;
      rx_hold    <= rx_hold - 1;
    end else if (hold_req && !hold_done) begin
      out_tready <= 1'b0;
      rx_hold    <= LONG_HOLD;
      hold_done  <= 1'b1;
    end else begin
      case (rx_cyc[9:8])
        2'd0:    out_tready <= 1'b1;
        2'd1:    out_tready <= 1'($urandom_range(0, 1));
        2'd2:    out_tready <= ($urandom_range(0, 7) != 0);
        default: out_tready <= (rx_cyc[2:0] != 3'd5 && rx_cyc[2:0] != 3'd6);
      endcase
    end
  end

  result_t got_res;
  result_t want_res;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res = result_t'(out_tdata[RES_W-1:0]);
      verdicts_seen++;
      if (int'(got_res.status) < 6) status_seen[int'(got_res.status)]++;
      if (verdict_q.size() == 0) begin
        note_mismatch("verdict with none pending, status", '0, 20'(got_res.status));
      end else begin
        want_res = verdict_q.pop_front();
        if (got_res.status != want_res.status)
          note_mismatch("status", 20'(want_res.status), 20'(got_res.status));
        if (got_res.glyph_count != want_res.glyph_count)
          note_mismatch("glyph_count", 20'(want_res.glyph_count), 20'(got_res.glyph_count));
        if (got_res.non_ascii_count != want_res.non_ascii_count)
          note_mismatch("non_ascii_count", 20'(want_res.non_ascii_count),
                        20'(got_res.non_ascii_count));
        if (got_res.error_offset != want_res.error_offset)
          note_mismatch("error_offset", want_res.error_offset, got_res.error_offset);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles, %0d verdicts still pending",
               WATCHDOG_LIMIT, verdict_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int      i;
    result_t typed_res;
    dir_rows = '{
      // A single byte is too small even though it is no valid lead byte.
      '{8'hF8, 1'b1, 1'b1, ST_TOO_SMALL, 0, 0, 0},
      // Continuation byte where a lead byte belongs.
      '{8'h80, 1'b0, 1'b0, ST_OK, 0, 0, 0},
      '{8'h00, 1'b0, 1'b0, ST_OK, 0, 0, 0},
      '{8'h00, 1'b0, 1'b0, ST_OK, 0, 0, 0},
      '{8'h00, 1'b0, 1'b0, ST_OK, 0, 0, 0},
      '{8'h00, 1'b1, 1'b1, ST_BAD_UTF8, 0, 0, 0},
      // One complete control-character glyph.
      '{8'h00, 1'b0, 1'b0, ST_OK, 0, 0, 0},
      '{8'h00, 1'b0, 1'b0, ST_OK, 0, 0, 0},
      '{8'h01, 1'b0, 1'b0, ST_OK, 0, 0, 0},
      '{8'h01, 1'b0, 1'b0, ST_OK, 0, 0, 0},
      '{8'h01, 1'b0, 1'b0, ST_OK, 0, 0, 0},
      '{8'hAA, 1'b1, 1'b1, ST_OK, 1, 1, 0},
      // Largest legal header, buffer ends on the stride byte.
      '{8'hC3, 1'b0, 1'b0, ST_OK, 0, 0, 0},
      '{8'hA9, 1'b0, 1'b0, ST_OK, 0, 0, 0},
      '{8'hFF, 1'b0, 1'b0, ST_OK, 0, 0, 0},
      '{8'h80, 1'b0, 1'b0, ST_OK, 0, 0, 0},
      '{8'h40, 1'b0, 1'b0, ST_OK, 0, 0, 0},
      '{8'h08, 1'b1, 1'b1, ST_DATA_TRUNC, 0, 0, 0},
      // Width one past the limit.
      '{8'h7F, 1'b0, 1'b0, ST_OK, 0, 0, 0},
      '{8'h00, 1'b0, 1'b0, ST_OK, 0, 0, 0},
      '{8'h81, 1'b0, 1'b0, ST_OK, 0, 0, 0},
      '{8'h01, 1'b0, 1'b0, ST_OK, 0, 0, 0},
      '{8'h01, 1'b1, 1'b1, ST_BAD_HDR, 0, 0, 0},
      // Four-byte lead, buffer ends on the offset byte.
      '{8'hF4, 1'b0, 1'b0, ST_OK, 0, 0, 0},
      '{8'h8F, 1'b0, 1'b0, ST_OK, 0, 0, 0},
      '{8'hBF, 1'b0, 1'b0, ST_OK, 0, 0, 0},
      '{8'hBF, 1'b0, 1'b0, ST_OK, 0, 0, 0},
      '{8'h00, 1'b1, 1'b1, ST_HDR_TRUNC, 0, 0, 0}
    };
    clear_parser();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < $size(dir_rows); i++) begin
      typed_res                 = '0;
      typed_res.status          = dir_rows[i].st;
      typed_res.glyph_count     = 18'(dir_rows[i].glyphs);
      typed_res.non_ascii_count = 18'(dir_rows[i].wide);
      typed_res.error_offset    = 20'(dir_rows[i].offs);
      send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed, typed_res);
      if (dir_rows[i].last) buffers_sent++;
    end
    drain_verdicts();
    bytes_sent   = 0;
    verdicts_due = 0;

    while (bytes_sent < RANDOM_BYTES || verdicts_due < MIN_VERDICTS) begin
      if (buffers_sent == 40) begin
        // Hold the receiver off and keep short buffers coming back to back, so the
        // verdict queue fills and the input stalls.
        hold_req <= 1'b1;
        tx_burst_left = 1000;
        repeat (12) begin
          buf_q.delete();
          repeat ($urandom_range(1, 6)) buf_q.push_back(8'($urandom));
          send_buffer();
        end
        tx_burst_left = 0;
      end
      if (buffers_sent == 70) drain_verdicts();
      build_buffer();
      send_buffer();
    end

    drain_verdicts();
    repeat (8) @(posedge clk);
    $display("Sent %0d buffers (%0d random bytes); checked %0d verdicts, %0d mismatches.",
             buffers_sent, bytes_sent, verdicts_seen, mismatches);
    $display("Verdicts: ok %0d, too_small %0d, bad_utf8 %0d, hdr_trunc %0d, bad_hdr %0d, data_trunc %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
